// ===== rtl/assert_macros.svh =====
// Assertion macros used by the command parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/ccp_pkg.sv =====
// Package with constants, types and the command table of the command parser.
package ccp_pkg;
    localparam int NUM_COMMANDS = 94;
    localparam int MAX_PARAM_CHARS = 16;
    localparam int MAX_LINE_CHARS = 128;
    localparam int PARAM_LIMIT = (MAX_PARAM_CHARS < 16) ? MAX_PARAM_CHARS : 16;
    localparam int LINE_LIMIT = MAX_LINE_CHARS - 2;
    localparam int PIDX_W = $clog2(PARAM_LIMIT);
    localparam int PCNT_W = $clog2(PARAM_LIMIT + 1);
    localparam logic [20:0] MAG_MAX = 21'h1FFFFF;

    localparam logic [7:0] CH_TERM = 8'h3B;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_NUM = 2'd1;
    localparam logic [1:0] K_BOOL = 2'd2;
    localparam logic [1:0] K_STR = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_NONNUM = 3'd3;
    localparam logic [2:0] ST_LONG = 3'd4;

    typedef struct packed {
        logic [15:0] word_low;
        logic [1:0]  kind;
        logic [15:0] lo;
        logic [15:0] hi;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  cmd_index;
        logic [1:0]  param_kind;
        logic [15:0] num_value;
        logic        bool_value;
        logic [7:0]  text_char;
        logic        last;
    } result_t;

    // Search request from the line collector to the finishing sequencer.
    typedef struct packed {
        logic        overflow;
        logic        short_line;
        logic [31:0] word;
        logic [PCNT_W-1:0] plen;
        logic        numeric;
        logic        negative;
        logic [20:0] magnitude;
    } line_t;

    function automatic entry_t mk(input byte c, input byte d, input logic [1:0] k,
                                  input int lo, input int hi);
        entry_t e;
        e.word_low = {c, d};
        e.kind = k;
        e.lo = 16'(lo);
        e.hi = 16'(hi);
        return e;
    endfunction

    function automatic entry_t rom_entry(input logic [6:0] i);
        entry_t e;
        case (i)
            7'd0: e = mk("A","G",K_NUM,0,100);   7'd1: e = mk("L","A",K_NUM,0,100);
            7'd2: e = mk("L","E",K_NUM,0,100);   7'd3: e = mk("P","A",K_NUM,0,4);
            7'd4: e = mk("P","B",K_NUM,0,4);     7'd5: e = mk("A","R",K_NUM,-20,120);
            7'd6: e = mk("A","S",K_NUM,-20,120); 7'd7: e = mk("G","T",K_NUM,0,5);
            7'd8: e = mk("G","U",K_NUM,0,5);     7'd9: e = mk("F","L",K_NUM,-9999,9999);
            7'd10: e = mk("F","S",K_NUM,-9999,9999);
            7'd11: e = mk("F","H",K_NUM,-9999,9999);
            7'd12: e = mk("F","R",K_NUM,-9999,9999);
            7'd13: e = mk("P","C",K_NUM,0,100);  7'd14: e = mk("M","G",K_NUM,-50,70);
            7'd15: e = mk("F","A",K_STR,0,0);    7'd16: e = mk("F","B",K_STR,0,0);
            7'd17: e = mk("A","E",K_NUM,0,99);   7'd18: e = mk("A","F",K_NUM,0,99);
            7'd19: e = mk("B","E",K_NUM,0,99);   7'd20: e = mk("B","F",K_NUM,0,99);
            7'd21: e = mk("V","G",K_NUM,0,1000); 7'd22: e = mk("X","H",K_NUM,0,2000);
            7'd23: e = mk("V","E",K_BOOL,0,1);   7'd24: e = mk("C","L",K_NUM,200,2250);
            7'd25: e = mk("C","S",K_NUM,1,60);   7'd26: e = mk("T","X",K_BOOL,0,1);
            7'd27: e = mk("T","U",K_BOOL,0,1);   7'd28: e = mk("B","D",K_NONE,0,0);
            7'd29: e = mk("B","U",K_NONE,0,0);   7'd30: e = mk("B","S",K_STR,0,999);
            7'd31: e = mk("B","A",K_NONE,0,0);   7'd32: e = mk("B","B",K_NONE,0,0);
            7'd33: e = mk("B","T",K_STR,0,999);  7'd34: e = mk("M","D",K_NUM,0,11);
            7'd35: e = mk("M","E",K_NUM,0,11);   7'd36: e = mk("R","T",K_BOOL,0,1);
            7'd37: e = mk("R","U",K_NONE,0,0);   7'd38: e = mk("R","D",K_NONE,0,0);
            7'd39: e = mk("S","P",K_BOOL,0,1);   7'd40: e = mk("C","N",K_BOOL,0,1);
            7'd41: e = mk("C","O",K_BOOL,0,1);   7'd42: e = mk("U","X",K_BOOL,0,1);
            7'd43: e = mk("U","Y",K_BOOL,0,1);   7'd44: e = mk("S","M",K_NUM,0,1260);
            7'd45: e = mk("R","M",K_STR,0,9999); 7'd46: e = mk("N","R",K_BOOL,0,1);
            7'd47: e = mk("N","S",K_BOOL,0,1);   7'd48: e = mk("N","V",K_BOOL,0,1);
            7'd49: e = mk("N","W",K_BOOL,0,1);   7'd50: e = mk("N","A",K_BOOL,0,1);
            7'd51: e = mk("N","B",K_BOOL,0,1);   7'd52: e = mk("N","C",K_BOOL,0,1);
            7'd53: e = mk("N","D",K_BOOL,0,1);   7'd54: e = mk("N","N",K_BOOL,0,1);
            7'd55: e = mk("N","O",K_BOOL,0,1);   7'd56: e = mk("N","T",K_BOOL,0,1);
            7'd57: e = mk("N","U",K_BOOL,0,1);   7'd58: e = mk("M","A",K_BOOL,0,1);
            7'd59: e = mk("M","B",K_BOOL,0,1);   7'd60: e = mk("P","S",K_BOOL,0,1);
            7'd61: e = mk("S","Q",K_NUM,0,160);  7'd62: e = mk("S","X",K_NUM,0,160);
            7'd63: e = mk("S","O",K_BOOL,0,1);   7'd64: e = mk("S","V",K_BOOL,0,1);
            7'd65: e = mk("V","S",K_NONE,0,2);   7'd66: e = mk("X","N",K_NUM,0,8191);
            7'd67: e = mk("X","O",K_NUM,0,8191); 7'd68: e = mk("X","V",K_NUM,0,1023);
            7'd69: e = mk("A","C",K_NUM,0,24);   7'd70: e = mk("D","B",K_BOOL,0,1);
            7'd71: e = mk("D","C",K_NUM,0,5000);
            7'd72: e = mk("D","D",K_NUM,-18000,18000);
            7'd73: e = mk("D","E",K_BOOL,0,1);   7'd74: e = mk("D","G",K_NUM,0,5000);
            7'd75: e = mk("D","H",K_NUM,0,2);    7'd76: e = mk("S","W",K_BOOL,0,1);
            7'd77: e = mk("R","X",K_NUM,0,31);   7'd78: e = mk("R","Y",K_NUM,0,31);
            7'd79: e = mk("C","P",K_BOOL,0,1);   7'd80: e = mk("C","T",K_NUM,0,20);
            7'd81: e = mk("L","I",K_BOOL,0,1);   7'd82: e = mk("U","T",K_BOOL,0,1);
            7'd83: e = mk("U","S",K_NONE,0,0);   7'd84: e = mk("M","O",K_BOOL,0,1);
            7'd85: e = mk("X","D",K_NONE,0,0);   7'd86: e = mk("X","U",K_NONE,0,0);
            7'd87: e = mk("X","S",K_BOOL,0,1);   7'd88: e = mk("X","C",K_NONE,0,0);
            7'd89: e = mk("R","C",K_NONE,0,0);   7'd90: e = mk("S","Y",K_BOOL,0,1);
            7'd91: e = mk("F","I",K_NUM,0,11);   7'd92: e = mk("F","J",K_NUM,0,11);
            7'd93: e = mk("Y","R",K_BOOL,0,1);
            default: e = '0;
        endcase
        return e;
    endfunction
endpackage

// ===== rtl/ccp_collect.sv =====
// Line collector: packs the command word, stores parameter characters, accumulates digits.
module ccp_collect (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [7:0]                ch,
    input  logic [ccp_pkg::PIDX_W-1:0] rd_addr,
    output logic [7:0]                rd_data,
    output ccp_pkg::line_t            line
);
    logic [7:0]  line_count_reg;
    logic [31:0] command_word_reg;
    logic [20:0] magnitude_acc_reg;
    logic        negative_sign_reg;
    logic        digits_stopped_reg;
    logic        first_is_numeric_reg;
    logic        line_overflow_reg;
    logic [7:0]  param_store [ccp_pkg::PARAM_LIMIT];

    logic        is_term;
    logic        is_digit;
    logic [7:0]  up_ch;
    logic [7:0]  pos;
    logic        full;
    logic [24:0] mag_mul;
    logic [3:0]  dval;

    assign is_term = (ch == ccp_pkg::CH_TERM);
    assign is_digit = (ch >= "0") && (ch <= "9");
    assign dval = 4'(ch - "0");
    assign up_ch = ((ch >= "a") && (ch <= "z")) ? ch - ccp_pkg::CASE_OFFSET : ch;
    assign pos = line_count_reg - 8'd4;
    assign full = (line_count_reg >= 8'(ccp_pkg::LINE_LIMIT))
        || (pos >= 8'(ccp_pkg::PARAM_LIMIT));
    assign mag_mul = {1'b0, magnitude_acc_reg, 3'b000} + {3'b000, magnitude_acc_reg, 1'b0}
        + 25'(dval);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            command_word_reg <= '0;
            magnitude_acc_reg <= '0;
            negative_sign_reg <= 1'b0;
            digits_stopped_reg <= 1'b0;
            first_is_numeric_reg <= 1'b0;
            line_overflow_reg <= 1'b0;
        end
        else if (take)
        begin
            if (is_term)
            begin
                line_count_reg <= '0;
                command_word_reg <= '0;
                magnitude_acc_reg <= '0;
                negative_sign_reg <= 1'b0;
                digits_stopped_reg <= 1'b0;
                first_is_numeric_reg <= 1'b0;
                line_overflow_reg <= 1'b0;
            end
            else if (!line_overflow_reg)
            begin
                if (line_count_reg < 8'd4)
                begin
                    command_word_reg <= {command_word_reg[23:0], up_ch};
                    line_count_reg <= line_count_reg + 8'd1;
                end
                else if (full)
                begin
                    line_overflow_reg <= 1'b1;
                end
                else
                begin
                    line_count_reg <= line_count_reg + 8'd1;
                    if (pos == 8'd0)
                    begin
                        first_is_numeric_reg <= is_digit || ch == ccp_pkg::CH_PLUS
                            || ch == ccp_pkg::CH_MINUS;
                        negative_sign_reg <= (ch == ccp_pkg::CH_MINUS);
                        magnitude_acc_reg <= is_digit ? 21'(dval) : '0;
                        digits_stopped_reg <= !(is_digit || ch == ccp_pkg::CH_PLUS
                            || ch == ccp_pkg::CH_MINUS);
                    end
                    else if (!digits_stopped_reg && is_digit)
                    begin
                        magnitude_acc_reg <= (mag_mul > 25'(ccp_pkg::MAG_MAX))
                            ? ccp_pkg::MAG_MAX : mag_mul[20:0];
                    end
                    else if (!is_digit)
                    begin
                        digits_stopped_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !is_term && !line_overflow_reg && line_count_reg >= 8'd4 && !full)
        begin
            param_store[pos[ccp_pkg::PIDX_W-1:0]] <= ch;
        end
        rd_data <= param_store[rd_addr];
    end

    always_comb
    begin
        line.overflow = line_overflow_reg;
        line.short_line = (line_count_reg < 8'd4);
        line.word = command_word_reg;
        line.plen = ccp_pkg::PCNT_W'(pos);
        line.numeric = first_is_numeric_reg;
        line.negative = negative_sign_reg;
        line.magnitude = magnitude_acc_reg;
    end
endmodule

// ===== rtl/cat_command_parser_core.sv =====
// Top level of the command parser: stream ports, table search sequencer and result register.
// Sequence: a ';' walks the command table one entry per cycle; a hit with a numeric parameter
// then passes S_CLAMP and S_OUT, a string hit goes to S_STR, and an over-long or short line
// goes to S_OUT without walking the table. Throughput: string characters come out through
// S_STR and S_OUT in turn, S_STR waiting for a free output slot, and no byte is taken while
// a result waits. Reset: rst_n is asynchronous, active low, clears line and sequencer.
`include "assert_macros.svh"
module cat_command_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [9:3] cmd_index, [11:10] param_kind, [27:12] num_value,
    // [28] bool_value, [36:29] text_char, zero fill to 40 bits
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast    // last
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_CLAMP  = 3'd2;
    localparam logic [2:0] S_STR    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [6:0] idx_reg, idx_next;
    logic [ccp_pkg::PCNT_W-1:0] sidx_reg, sidx_next;
    logic [15:0] val_reg, val_next;
    logic        bool_reg, bool_next;
    ccp_pkg::result_t res_reg, res_next;
    logic        res_valid_reg, res_valid_next;
    logic        res_str_reg, res_str_next;
    ccp_pkg::line_t held_reg, held_next;

    ccp_pkg::line_t line;
    ccp_pkg::entry_t ent;
    logic [7:0]  rd_data;
    logic        take;
    logic        term;
    logic [21:0] sval;
    logic        hit;

    assign s_axis_tready = (state_reg == S_IDLE) && !res_valid_reg;
    assign take = s_axis_tvalid && s_axis_tready;
    // The collector clears on ';', so the line is latched into the sequencer first.
    assign term = take && (s_axis_tdata == ccp_pkg::CH_TERM);

    ccp_collect u_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .ch      (s_axis_tdata),
        .rd_addr (sidx_reg[ccp_pkg::PIDX_W-1:0]),
        .rd_data (rd_data),
        .line    (line)
    );

    assign ent = ccp_pkg::rom_entry(idx_reg);
    assign hit = (held_reg.word == {16'h5A5A, ent.word_low});
    assign sval = held_reg.negative ? -{1'b0, held_reg.magnitude}
                                    : {1'b0, held_reg.magnitude};

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        sidx_next = sidx_reg;
        val_next = val_reg;
        bool_next = bool_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg;
        res_str_next = res_str_reg;
        held_next = held_reg;
        if (res_valid_reg && m_axis_tready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (term)
                begin
                    held_next = line;
                    idx_next = '0;
                    sidx_next = '0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                res_next = '0;
                res_next.last = 1'b1;
                if (held_reg.overflow)
                begin
                    res_next.status = ccp_pkg::ST_LONG;
                    state_next = S_OUT;
                end
                else if (held_reg.short_line)
                begin
                    res_next.status = ccp_pkg::ST_SHORT;
                    state_next = S_OUT;
                end
                else if (hit)
                begin
                    res_next.cmd_index = idx_reg;
                    // Saturate the signed value to 16 bits before clamping.
                    val_next = sval[21] ? 16'h8000 : 16'h7FFF;
                    if (sval[21:15] == {7{sval[15]}})
                    begin
                        val_next = sval[15:0];
                    end
                    bool_next = (sval == 22'd1);
                    if (held_reg.plen == '0)
                    begin
                        res_next.param_kind = ccp_pkg::K_NONE;
                        state_next = S_OUT;
                    end
                    else if (ent.kind == ccp_pkg::K_STR)
                    begin
                        state_next = S_STR;
                    end
                    else if (!held_reg.numeric)
                    begin
                        res_next.status = ccp_pkg::ST_NONNUM;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_CLAMP;
                    end
                end
                else if (idx_reg == 7'(ccp_pkg::NUM_COMMANDS - 1))
                begin
                    res_next.status = ccp_pkg::ST_UNKNOWN;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 7'd1;
                end
            end
            S_CLAMP:
            begin
                if (ent.kind == ccp_pkg::K_BOOL)
                begin
                    res_next.param_kind = ccp_pkg::K_BOOL;
                    res_next.bool_value = bool_reg;
                end
                else
                begin
                    res_next.param_kind = ccp_pkg::K_NUM;
                    if ($signed(val_reg) < $signed(ent.lo))
                    begin
                        res_next.num_value = ent.lo;
                    end
                    else if ($signed(val_reg) > $signed(ent.hi))
                    begin
                        res_next.num_value = ent.hi;
                    end
                    else
                    begin
                        res_next.num_value = val_reg;
                    end
                end
                state_next = S_OUT;
            end
            S_STR:
            begin
                // Read data of the character at sidx_reg is ready; wait for a free slot.
                if (!res_valid_reg || m_axis_tready)
                begin
                    res_next.param_kind = ccp_pkg::K_STR;
                    res_next.text_char = rd_data;
                    res_next.last = (sidx_reg + 1'b1 == held_reg.plen);
                    res_valid_next = 1'b1;
                    res_str_next = 1'b1;
                    sidx_next = sidx_reg + 1'b1;
                    state_next = (sidx_reg + 1'b1 == held_reg.plen) ? S_IDLE : S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_str_reg)
                begin
                    // Passing through S_OUT lets the next character's read data settle.
                    state_next = S_STR;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_next == S_IDLE && state_reg != S_IDLE)
        begin
            res_str_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
            res_str_reg <= 1'b0;
            idx_reg <= '0;
            sidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
            res_str_reg <= res_str_next;
            idx_reg <= idx_next;
            sidx_reg <= sidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        bool_reg <= bool_next;
        res_reg <= res_next;
        held_reg <= held_next;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tlast = res_reg.last;
    assign m_axis_tdata = {3'b000, res_reg.text_char, res_reg.bool_value, res_reg.num_value,
                           res_reg.param_kind, res_reg.cmd_index, res_reg.status};

    `ASSERT_IMPLIES(a_no_take_busy, clk, rst_n, state_reg != S_IDLE, !s_axis_tready)
    `ASSERT_IMPLIES(a_idx_range, clk, rst_n, state_reg == S_SEARCH,
                    idx_reg < 7'(ccp_pkg::NUM_COMMANDS))
    `ASSERT_NEXT(a_term_search, clk, rst_n, term, state_reg == S_SEARCH)
    `ASSERT_IMPLIES(a_err_last, clk, rst_n, m_axis_tvalid && res_reg.status != ccp_pkg::ST_OK,
                    m_axis_tlast)
endmodule
